// ===== hdl/csma_pkg.sv =====
// Shared types and constants for the CSMA-CA backoff controller.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package csma_pkg;

    typedef enum logic [2:0] {
        CMD_NEW_FRAME = 3'd0,
        CMD_ATTEMPT   = 3'd1,
        CMD_CCA_CLEAR = 3'd2,
        CMD_CCA_BUSY  = 3'd3,
        CMD_CCA_NOTV  = 3'd4,
        CMD_DONE      = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_WAIT    = 3'd1,
        ACT_TX      = 3'd2,
        ACT_GIVEUP  = 3'd3,
        ACT_RECHECK = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_HOLD
    } ctrl_state_t;

    localparam logic [2:0] CFG_SLOTTED      = 3'd0;
    localparam logic [2:0] CFG_MIN_BE       = 3'd1;
    localparam logic [2:0] CFG_MAX_BE       = 3'd2;
    localparam logic [2:0] CFG_MAX_BUSY     = 3'd3;
    localparam logic [2:0] CFG_MAX_ATTEMPTS = 3'd4;
    localparam logic [2:0] CFG_BATT_SAVE    = 3'd5;

    localparam int DRAW_STEPS = 8;

    typedef struct packed {
        logic capture;
        logic mod_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_draw;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/csma_ca_backoff_controller.sv =====
// Top level of the CSMA-CA backoff controller: sequencer plus datapath.
// Sequence: a word without a random draw goes from capture straight to the
// output register load; a word with a draw first runs the 8 steps of the
// one-bit-a-cycle remainder unit. A new word is taken only after the last
// is loaded, later while a previous result word is still held at the output.
// Reset: configuration returns to its defaults, frame state clears to zero.
`default_nettype none

module csma_ca_backoff_controller
    import csma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] command,
    input  wire logic [2:0] attempts_request,
    input  wire logic       is_broadcast,
    input  wire logic [7:0] random_draw,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      action,
    output logic [7:0]      backoff_periods,
    output logic [2:0]      attempts_left,
    output logic [3:0]      backoff_exp_now
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    csma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    csma_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .attempts_request (attempts_request),
        .is_broadcast     (is_broadcast),
        .random_draw      (random_draw),
        .action           (action),
        .backoff_periods  (backoff_periods),
        .attempts_left    (attempts_left),
        .backoff_exp_now  (backoff_exp_now)
    );

endmodule

`default_nettype wire

// ===== hdl/csma_ctrl.sv =====
// Sequencer of the CSMA-CA backoff controller: accepts a word, runs the
// remainder steps when a draw is needed and loads the output register.
// Depends on csma_pkg.
`default_nettype none

module csma_ctrl
    import csma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = status.need_draw ? ST_DRAW : ST_HOLD;
                end
            end
            ST_DRAW:
            begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'(DRAW_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/csma_dp.sv =====
// Datapath of the CSMA-CA backoff controller: configuration and frame state,
// event decode, a bit-serial remainder unit for the backoff draw, and the
// output register. Depends on csma_pkg.
`default_nettype none

module csma_dp
    import csma_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      status,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    input  wire logic [2:0] command,
    input  wire logic [2:0] attempts_request,
    input  wire logic       is_broadcast,
    input  wire logic [7:0] random_draw,
    output logic [2:0]      action,
    output logic [7:0]      backoff_periods,
    output logic [2:0]      attempts_left,
    output logic [3:0]      backoff_exp_now
);

    logic       slotted_reg;
    logic [3:0] min_be_reg;
    logic [3:0] max_be_reg;
    logic [2:0] max_busy_reg;
    logic [2:0] max_att_reg;
    logic       batt_reg;

    logic       pending_reg, pending_next;
    logic [2:0] att_reg, att_next;
    logic [2:0] busy_reg, busy_next;
    logic [1:0] cw_reg, cw_next;
    logic [3:0] be_reg, be_next;

    act_t       act_next;
    logic [7:0] fixed_next;
    logic       draw_next;

    act_t       res_act_reg;
    logic [7:0] res_fixed_reg;
    logic       res_draw_reg;
    logic [2:0] res_att_reg;
    logic [3:0] res_be_reg;

    logic [7:0] dividend_reg;
    logic [7:0] rem_reg;
    logic [7:0] mod_reg;

    logic [1:0] win;
    logic [3:0] be_start;
    logic [4:0] be_inc;
    logic [3:0] be_capped;
    logic [3:0] busy_inc;
    logic [2:0] att_dec;
    logic [3:0] e_draw;
    logic [8:0] mod_full;
    logic [8:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slotted_reg  <= 1'b1;
            min_be_reg   <= 4'd3;
            max_be_reg   <= 4'd5;
            max_busy_reg <= 3'd4;
            max_att_reg  <= 3'd3;
            batt_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOTTED:      slotted_reg  <= cfg_data[0];
                CFG_MIN_BE:       min_be_reg   <= cfg_data;
                CFG_MAX_BE:       max_be_reg   <= cfg_data;
                CFG_MAX_BUSY:     max_busy_reg <= cfg_data[2:0];
                CFG_MAX_ATTEMPTS: max_att_reg  <= cfg_data[2:0];
                CFG_BATT_SAVE:    batt_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        win       = slotted_reg ? 2'd2 : 2'd1;
        be_start  = (batt_reg && (min_be_reg > 4'd2)) ? 4'd2 : min_be_reg;
        be_inc    = {1'b0, be_reg} + 5'd1;
        be_capped = (be_inc > {1'b0, max_be_reg}) ? max_be_reg : be_inc[3:0];
        busy_inc  = {1'b0, busy_reg} + 4'd1;
        att_dec   = (att_reg != 3'd0) ? (att_reg - 3'd1) : 3'd0;

        pending_next = pending_reg;
        att_next     = att_reg;
        busy_next    = busy_reg;
        cw_next      = cw_reg;
        be_next      = be_reg;
        act_next     = ACT_NONE;
        fixed_next   = 8'd0;
        draw_next    = 1'b0;

        case (cmd_t'(command))
            CMD_NEW_FRAME:
            begin
                pending_next = 1'b1;
                if (is_broadcast)
                begin
                    att_next = 3'd1;
                end
                else
                begin
                    att_next = (attempts_request != 3'd0) ? attempts_request : max_att_reg;
                end
            end
            CMD_ATTEMPT:
            begin
                if (pending_reg)
                begin
                    if (att_reg == 3'd0)
                    begin
                        pending_next = 1'b0;
                        act_next     = ACT_GIVEUP;
                    end
                    else
                    begin
                        busy_next = 3'd0;
                        cw_next   = win;
                        be_next   = be_start;
                        act_next  = ACT_WAIT;
                        draw_next = 1'b1;
                    end
                end
            end
            CMD_CCA_CLEAR:
            begin
                if (pending_reg)
                begin
                    if (cw_reg > 2'd1)
                    begin
                        cw_next    = cw_reg - 2'd1;
                        act_next   = ACT_WAIT;
                        fixed_next = 8'd1;
                    end
                    else
                    begin
                        cw_next  = 2'd0;
                        att_next = att_dec;
                        act_next = ACT_TX;
                    end
                end
            end
            CMD_CCA_BUSY:
            begin
                if (pending_reg)
                begin
                    cw_next = win;
                    be_next = be_capped;
                    if (busy_inc > {1'b0, max_busy_reg})
                    begin
                        att_next = att_dec;
                        if (att_dec == 3'd0)
                        begin
                            pending_next = 1'b0;
                            act_next     = ACT_GIVEUP;
                        end
                        else
                        begin
                            busy_next = 3'd0;
                            be_next   = be_start;
                            act_next  = ACT_WAIT;
                            draw_next = 1'b1;
                        end
                    end
                    else
                    begin
                        busy_next = busy_inc[2:0];
                        act_next  = ACT_WAIT;
                        draw_next = 1'b1;
                    end
                end
            end
            CMD_CCA_NOTV:
            begin
                if (pending_reg)
                begin
                    act_next = ACT_RECHECK;
                end
            end
            CMD_DONE:
            begin
                pending_next = 1'b0;
                att_next     = 3'd0;
            end
            default:
            begin
            end
        endcase

        if (be_next == 4'd0)
        begin
            e_draw = 4'd1;
        end
        else if (be_next > 4'd8)
        begin
            e_draw = 4'd8;
        end
        else
        begin
            e_draw = be_next;
        end
        mod_full = (9'd1 << e_draw) - 9'd1;

        trial = {rem_reg, dividend_reg[7]};
    end

    assign status.need_draw = draw_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            att_reg     <= '0;
            busy_reg    <= '0;
            cw_reg      <= '0;
            be_reg      <= '0;
        end
        else if (cmd.capture)
        begin
            pending_reg <= pending_next;
            att_reg     <= att_next;
            busy_reg    <= busy_next;
            cw_reg      <= cw_next;
            be_reg      <= be_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_act_reg   <= act_next;
            res_fixed_reg <= fixed_next;
            res_draw_reg  <= draw_next;
            res_att_reg   <= att_next;
            res_be_reg    <= be_next;
            dividend_reg  <= random_draw;
            rem_reg       <= 8'd0;
            mod_reg       <= mod_full[7:0];
        end
        else if (cmd.mod_step)
        begin
            dividend_reg <= {dividend_reg[6:0], 1'b0};
            if (trial >= {1'b0, mod_reg})
            begin
                rem_reg <= 8'(trial - {1'b0, mod_reg});
            end
            else
            begin
                rem_reg <= trial[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            action          <= res_act_reg;
            backoff_periods <= res_draw_reg ? (rem_reg + 8'd1) : res_fixed_reg;
            attempts_left   <= res_att_reg;
            backoff_exp_now <= res_be_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/csma_checker.sv =====
// Port-level checks for the CSMA-CA backoff controller, bound to the top level.
// Depends on csma_pkg and csma_ca_backoff_controller.
`default_nettype none

module csma_checker
    import csma_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] action,
    input wire logic [7:0] backoff_periods
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
            && $stable(backoff_periods))
        else $error("Stalled output word changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input taken while a word is still in work.");

    a_wait_has_periods: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_WAIT) |-> backoff_periods != 8'd0)
        else $error("Wait action without backoff periods.");

    a_periods_only_on_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_WAIT) |-> backoff_periods == 8'd0)
        else $error("Backoff periods given with an action other than wait.");

endmodule

bind csma_ca_backoff_controller csma_checker u_csma_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .backoff_periods (backoff_periods)
);

`default_nettype wire
